/* design/itp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the infix to postfix converter.
package itp_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // ASCII codes of the operators and parentheses
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_POW    = 3'd5
  } op_code_e;

  // Character classes
  typedef enum logic [2:0] {
    K_IGNORE   = 3'd0,
    K_OPERAND  = 3'd1,
    K_OPERATOR = 3'd2,
    K_LPAREN   = 3'd3,
    K_RPAREN   = 3'd4
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e       kind;
    op_code_e    code;
    logic [7:0]  sym;
    logic        last;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       done;
    logic       err;
  } res_t;

endpackage

/* design/infix_to_postfix_converter.sv */
`timescale 1ns / 1ps
// Top level of the infix to postfix converter.
// Takes an infix expression one ASCII character per item and returns its postfix form.
// Operands pass straight through, + - * / ^ and '(' go onto a 32-entry operator stack, ')'
// unwinds to its '(' and the item flagged with tlast flushes the stack and closes with a
// done marker (tuser[1]), after which the error flag and stack start afresh. The front
// classifies each character in the cycle it is taken, drops ignored ones unless they carry
// tlast, and queues the rest in a four-entry command queue; the stack engine then fetches
// each command and works through it one stack step at a time: one step per operator it pops
// plus a closing step, and for a final character one step per stack entry plus one for the
// done marker.
// Each result waits one stage so tlast can mark the last result of its character; the
// output register lets new characters enter while results are still being taken.
module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
  input  logic        s_axis_tlast,  // end_of_expression
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_symbol, [8] error, zero above
  output logic [1:0]  m_axis_tuser,  // [0] out_valid, [1] expression_done
  output logic        m_axis_tlast   // run_last
);

  logic push, pop, full, empty;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  itp_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  itp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (full),
    .empty_o     (empty)
  );

  itp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_data_i    (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  // Result packing
  assign m_axis_tdata = {7'd0, res.err, res.sym};
  assign m_axis_tuser = {res.done, res.sym_valid};

endmodule

/* design/itp_fifo.sv */
`timescale 1ns / 1ps
// Short command queue that decouples the classifier from the stack engine.
module itp_fifo
  import itp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/itp_front.sv */
`timescale 1ns / 1ps
// Input side: takes characters and sorts them into command classes.
module itp_front
  import itp_pkg::*;
(
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  // Map one character onto its class and stack code
  function automatic cmd_t classify(input logic [7:0] sym, input logic last);
    cmd_t c;
    c.kind = K_IGNORE;
    c.code = OP_LPAREN;
    c.sym  = sym;
    c.last = last;
    case (sym)
      CH_ADD: begin
        c.kind = K_OPERATOR;
        c.code = OP_ADD;
      end
      CH_SUB: begin
        c.kind = K_OPERATOR;
        c.code = OP_SUB;
      end
      CH_MUL: begin
        c.kind = K_OPERATOR;
        c.code = OP_MUL;
      end
      CH_DIV: begin
        c.kind = K_OPERATOR;
        c.code = OP_DIV;
      end
      CH_POW: begin
        c.kind = K_OPERATOR;
        c.code = OP_POW;
      end
      CH_LPAREN: c.kind = K_LPAREN;
      CH_RPAREN: c.kind = K_RPAREN;
      default: begin
        // digits, upper and lower case letters
        if (sym inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
          c.kind = K_OPERAND;
        end
      end
    endcase
    return c;
  endfunction

  cmd_t cmd;

  assign cmd        = classify(s_tdata_i, s_tlast_i);
  assign s_tready_o = !full_i;
  assign cmd_o      = cmd;

  // Ignored characters only matter when they close an expression
  assign push_o = s_tvalid_i && !full_i && ((cmd.kind != K_IGNORE) || s_tlast_i);

endmodule

/* design/itp_back.sv */
`timescale 1ns / 1ps
// Stack engine: runs commands against the operator stack and emits result items.
module itp_back
  import itp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o,
  output logic out_last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  function automatic logic [1:0] op_weight(input op_code_e c);
    case (c)
      OP_ADD, OP_SUB: return 2'd1;
      OP_MUL, OP_DIV: return 2'd2;
      OP_POW:         return 2'd3;
      default:        return 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input op_code_e c);
    case (c)
      OP_LPAREN: return CH_LPAREN;
      OP_ADD:    return CH_ADD;
      OP_SUB:    return CH_SUB;
      OP_MUL:    return CH_MUL;
      OP_DIV:    return CH_DIV;
      OP_POW:    return CH_POW;
      default:   return 8'h00;
    endcase
  endfunction

  // Stacked operator leaves before the incoming one; ^ binds to the right
  function automatic logic goes_first(input op_code_e top, input op_code_e inc);
    logic [1:0] wt;
    logic [1:0] wi;
    wt = op_weight(top);
    wi = op_weight(inc);
    if (wt == wi) begin
      return top != OP_POW;
    end
    return wt > wi;
  endfunction

  logic [1:0]           state_q, state_d;
  cmd_t                 cmd_q;
  op_code_e             stack_q [STACK_DEPTH];
  logic [STK_CNT_W-1:0] count_q, count_d;
  logic                 err_q, err_d;

  logic                 hold_v_q, hold_v_d;
  logic                 hold_end_q, hold_end_d;
  res_t                 hold_q;
  logic                 out_v_q, out_v_d;
  res_t                 out_q;
  logic                 out_last_q;

  logic                 out_free, res_ok, move;
  logic [STK_CNT_W-1:0] cnt_dec;
  logic [STK_IDX_W-1:0] top_idx;
  op_code_e             top;
  logic                 stk_empty, stk_full;
  logic                 produce, fin, cmd_end, push, dec, set_err, clr_err;
  res_t                 new_res;

  assign out_free  = !out_v_q || out_ready_i;
  assign res_ok    = !hold_v_q || out_free;
  assign cnt_dec   = count_q - STK_CNT_W'(1);
  assign top_idx   = cnt_dec[STK_IDX_W-1:0];
  assign top       = stack_q[top_idx];
  assign stk_empty = (count_q == '0);
  assign stk_full  = (count_q == STK_CNT_W'(STACK_DEPTH));

  // Step sequencer: one pop, push or marker per cycle, unless output stalls
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    produce = 1'b0;
    new_res = '0;
    fin     = 1'b0;
    push    = 1'b0;
    dec     = 1'b0;
    set_err = 1'b0;
    clr_err = 1'b0;
    cmd_end = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd_q.kind)
          K_OPERAND: begin
            if (res_ok) begin
              produce = 1'b1;
              new_res = '{sym: cmd_q.sym, sym_valid: 1'b1, done: 1'b0, err: err_q};
              fin     = 1'b1;
            end
          end
          K_OPERATOR: begin
            if (!stk_empty && top != OP_LPAREN && goes_first(top, cmd_q.code)) begin
              if (res_ok) begin
                produce = 1'b1;
                dec     = 1'b1;
                new_res = '{sym: op_char(top), sym_valid: 1'b1, done: 1'b0, err: err_q};
              end
            end else begin
              fin = 1'b1;
              if (stk_full) begin
                set_err = 1'b1;
              end else begin
                push = 1'b1;
              end
            end
          end
          K_LPAREN: begin
            fin = 1'b1;
            if (stk_full) begin
              set_err = 1'b1;
            end else begin
              push = 1'b1;
            end
          end
          K_RPAREN: begin
            if (!stk_empty && top != OP_LPAREN) begin
              if (res_ok) begin
                produce = 1'b1;
                dec     = 1'b1;
                new_res = '{sym: op_char(top), sym_valid: 1'b1, done: 1'b0, err: err_q};
              end
            end else begin
              fin = 1'b1;
              if (stk_empty) begin
                set_err = 1'b1;
              end else begin
                dec = 1'b1;
              end
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          state_d = cmd_q.last ? ST_FLUSH : ST_IDLE;
          cmd_end = !cmd_q.last;
        end
      end
      ST_FLUSH: begin
        if (!stk_empty) begin
          if (top == OP_LPAREN) begin
            // leftover opening parenthesis is dropped
            dec     = 1'b1;
            set_err = 1'b1;
          end else if (res_ok) begin
            produce = 1'b1;
            dec     = 1'b1;
            new_res = '{sym: op_char(top), sym_valid: 1'b1, done: 1'b0, err: err_q};
          end
        end else if (res_ok) begin
          produce = 1'b1;
          new_res = '{sym: 8'h00, sym_valid: 1'b0, done: 1'b1, err: err_q};
          clr_err = 1'b1;
          cmd_end = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold stage: a result waits here until it is known whether it closes its item
  always_comb begin
    move       = hold_v_q && out_free && (hold_end_q || produce);
    hold_v_d   = produce ? 1'b1 : (move ? 1'b0 : hold_v_q);
    hold_end_d = produce ? cmd_end : (hold_end_q | cmd_end);
    out_v_d    = move ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);
    count_d    = count_q;
    if (push) begin
      count_d = count_q + STK_CNT_W'(1);
    end else if (dec) begin
      count_d = cnt_dec;
    end
    err_d = clr_err ? 1'b0 : (set_err ? 1'b1 : err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      err_q      <= 1'b0;
      hold_v_q   <= 1'b0;
      hold_end_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      err_q      <= err_d;
      hold_v_q   <= hold_v_d;
      hold_end_q <= hold_end_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers and stack storage
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (produce) begin
      hold_q <= new_res;
    end
    if (move) begin
      out_q      <= hold_q;
      out_last_q <= hold_end_q;
    end
    if (push) begin
      stack_q[count_q[STK_IDX_W-1:0]] <= cmd_q.code;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= STK_CNT_W'(STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && stk_empty && res_ok) |=> (count_q == '0 && !err_q))
    else $error("expression end left stack or error flag set");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.done) |-> (out_last_q && !out_q.sym_valid))
    else $error("done marker without last flag or with a symbol");

  a_hold_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_v_q && !out_free) |=> hold_v_q)
    else $error("held result dropped while output was stalled");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the infix to postfix converter: table-driven and random expressions.
module tb;
  import itp_pkg::*;

  localparam int NROWS        = 25;
  localparam int RANDOM_CHARS = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;
  localparam int STUCK_LIMIT  = 3000;

  // One postfix character as seen on the output side
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       run_last;
    logic       done;
    logic       err;
  } postfix_char_t;

  // One row of the directed plan; want is used only where typed is set
  typedef struct packed {
    logic [7:0]    sym;
    logic          last;
    int            reps;
    logic          typed;
    postfix_char_t want;
  } stim_row_t;

  localparam postfix_char_t NO_WANT = '0;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state
  op_code_e      opstack [STACK_DEPTH];
  int            opdepth;
  logic          expr_err;
  postfix_char_t step_q [$];
  postfix_char_t postfix_q [$];

  int mismatches  = 0;
  int live_chars  = 0;
  int stuck_cycles = 0;
  bit feed_busy   = 1'b0;
  bit drain_busy  = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  int stall_left  = 0;

  // Directed plan: extremes, every operator and the repair cases
  stim_row_t plan [NROWS] = '{
    '{"a",       1'b0, 1,  1'b1, '{"a", 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CH_ADD,    1'b0, 1,  1'b0, NO_WANT},
    '{"0",       1'b0, 1,  1'b1, '{"0", 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CH_MUL,    1'b0, 1,  1'b0, NO_WANT},
    '{"Z",       1'b0, 1,  1'b1, '{"Z", 1'b1, 1'b1, 1'b0, 1'b0}},
    '{CH_POW,    1'b0, 1,  1'b0, NO_WANT},
    '{"9",       1'b0, 1,  1'b0, NO_WANT},
    // ')' with no '(' unwinds the whole stack and flags
    '{CH_RPAREN, 1'b0, 1,  1'b0, NO_WANT},
    '{8'hFF,     1'b1, 1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'h00,     1'b1, 1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{CH_RPAREN, 1'b1, 1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    // overfill the stack, then flush the stranded '(' entries
    '{CH_LPAREN, 1'b0, 33, 1'b0, NO_WANT},
    '{"A",       1'b0, 1,  1'b0, NO_WANT},
    '{CH_DIV,    1'b0, 1,  1'b0, NO_WANT},
    '{8'h7F,     1'b1, 1,  1'b0, NO_WANT},
    // (x/y)*w- : brackets, precedence, operator as final item
    '{CH_LPAREN, 1'b0, 1,  1'b0, NO_WANT},
    '{"x",       1'b0, 1,  1'b0, NO_WANT},
    '{CH_DIV,    1'b0, 1,  1'b0, NO_WANT},
    '{"y",       1'b0, 1,  1'b0, NO_WANT},
    '{CH_RPAREN, 1'b0, 1,  1'b0, NO_WANT},
    '{CH_MUL,    1'b0, 1,  1'b0, NO_WANT},
    '{"w",       1'b0, 1,  1'b0, NO_WANT},
    '{CH_SUB,    1'b1, 1,  1'b0, NO_WANT},
    // 32 right-associative powers then a final operand: the longest run
    '{CH_POW,    1'b0, 32, 1'b0, NO_WANT},
    '{"q",       1'b1, 1,  1'b0, NO_WANT}
  };

  infix_to_postfix_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Character class and stack code of one input symbol
  function automatic kind_e classify(input logic [7:0] s, output op_code_e code);
    code = OP_LPAREN;
    case (s)
      CH_ADD: begin code = OP_ADD; return K_OPERATOR; end
      CH_SUB: begin code = OP_SUB; return K_OPERATOR; end
      CH_MUL: begin code = OP_MUL; return K_OPERATOR; end
      CH_DIV: begin code = OP_DIV; return K_OPERATOR; end
      CH_POW: begin code = OP_POW; return K_OPERATOR; end
      CH_LPAREN: return K_LPAREN;
      CH_RPAREN: return K_RPAREN;
      default: begin
        if ((s >= "0" && s <= "9") || (s >= "A" && s <= "Z") || (s >= "a" && s <= "z"))
          return K_OPERAND;
        return K_IGNORE;
      end
    endcase
  endfunction

  function automatic logic [7:0] op_char(input op_code_e code);
    case (code)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      default: return CH_LPAREN;
    endcase
  endfunction

  function automatic int rank(input op_code_e code);
    case (code)
      OP_ADD, OP_SUB: return 1;
      OP_MUL, OP_DIV: return 2;
      OP_POW:         return 3;
      default:        return 0;
    endcase
  endfunction

  // Stacked operator leaves before the incoming one; '^' binds to the right
  function automatic bit top_leaves_first(input op_code_e top, input op_code_e incoming);
    if (rank(top) == rank(incoming))
      return top != OP_POW;
    return rank(top) > rank(incoming);
  endfunction

  function automatic void put_out(input logic [7:0] s, input logic v, input logic done);
    step_q.push_back('{v ? s : 8'h00, v, 1'b0, done, expr_err});
  endfunction

  function automatic void pop_out();
    opdepth--;
    put_out(op_char(opstack[opdepth]), 1'b1, 1'b0);
  endfunction

  // Postfix characters caused by one accepted item, left in step_q
  function automatic void convert_char(input logic [7:0] s, input logic last);
    op_code_e code;
    kind_e    kind;
    step_q.delete();
    kind = classify(s, code);
    case (kind)
      K_OPERATOR: begin
        while (opdepth > 0 && opstack[opdepth-1] != OP_LPAREN &&
               top_leaves_first(opstack[opdepth-1], code))
          pop_out();
        if (opdepth < STACK_DEPTH) begin
          opstack[opdepth] = code;
          opdepth++;
        end else begin
          expr_err = 1'b1;
        end
      end
      K_OPERAND: put_out(s, 1'b1, 1'b0);
      K_LPAREN: begin
        if (opdepth < STACK_DEPTH) begin
          opstack[opdepth] = OP_LPAREN;
          opdepth++;
        end else begin
          expr_err = 1'b1;
        end
      end
      K_RPAREN: begin
        while (opdepth > 0 && opstack[opdepth-1] != OP_LPAREN)
          pop_out();
        if (opdepth > 0)
          opdepth--;
        else
          expr_err = 1'b1;
      end
      default: ;
    endcase
    // flush: stranded '(' entries are dropped and flagged
    if (last) begin
      while (opdepth > 0) begin
        if (opstack[opdepth-1] == OP_LPAREN) begin
          opdepth--;
          expr_err = 1'b1;
        end else begin
          pop_out();
        end
      end
      put_out(8'h00, 1'b0, 1'b1);
      expr_err = 1'b0;
    end
    if (step_q.size() > 0)
      step_q[step_q.size()-1].run_last = 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, none in busy stretches
  function automatic int pick_gap(input bit busy);
    int r;
    if (busy)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then record what it must produce
  task automatic send_char(input logic [7:0] s, input logic last, input logic typed,
                           input postfix_char_t want);
    int       gap;
    op_code_e code;
    gap = pick_gap(feed_busy);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    convert_char(s, last);
    if (typed)
      postfix_q.push_back(want);
    else
      foreach (step_q[i]) postfix_q.push_back(step_q[i]);
    if (last || classify(s, code) != K_IGNORE)
      live_chars++;
  endtask

  // Mostly well-formed expressions with random content, some broken or noisy
  task automatic feed_expression();
    logic [7:0] chars [$];
    int         terms;
    int         open_cnt;
    if ($urandom_range(0, 14) == 0) begin
      // long power chain, takes the stack close to or beyond its limit
      chars.push_back(pick_operand());
      repeat ($urandom_range(30, 34)) begin
        chars.push_back(CH_POW);
        chars.push_back(pick_operand());
      end
    end else begin
      terms = $urandom_range(1, 8);
      open_cnt = 0;
      for (int t = 0; t < terms; t++) begin
        while ($urandom_range(0, 3) == 0 && open_cnt < 6) begin
          chars.push_back(CH_LPAREN);
          open_cnt++;
        end
        chars.push_back(pick_operand());
        while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
          chars.push_back(CH_RPAREN);
          open_cnt--;
        end
        if (t < terms - 1)
          chars.push_back(pick_operator());
      end
      // most brackets get closed, a few are left for the flush
      while (open_cnt > 0) begin
        if ($urandom_range(0, 9) != 0)
          chars.push_back(CH_RPAREN);
        open_cnt--;
      end
    end
    if ($urandom_range(0, 3) == 0)
      chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      chars.insert($urandom_range(0, chars.size()), CH_RPAREN);
    if ($urandom_range(0, 9) == 0)
      chars.insert($urandom_range(0, chars.size()), CH_LPAREN);
    feed_busy = ($urandom_range(0, 3) == 0);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1, 1'b0, NO_WANT);
  endtask

  // Stimulus and end of run
  initial begin
    opdepth  = 0;
    expr_err = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[r])
      repeat (plan[r].reps) send_char(plan[r].sym, plan[r].last, plan[r].typed, plan[r].want);
    hold_req   = 1'b1;
    live_chars = 0;
    while (live_chars < RANDOM_CHARS)
      feed_expression();
    s_axis_tvalid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && postfix_q.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Output side readiness: random stalls, busy stretches, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 149) == 0)
        drain_busy = ~drain_busy;
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(drain_busy);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    postfix_char_t got;
    postfix_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
              m_axis_tdata[8]};
      if (postfix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result sym=%h v=%b last=%b done=%b err=%b", $realtime,
                   got.sym, got.sym_valid, got.run_last, got.done, got.err);
      end else begin
        want = postfix_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch want %h v%b l%b d%b e%b, got %h v%b l%b d%b e%b",
                     $realtime, want.sym, want.sym_valid, want.run_last, want.done, want.err,
                     got.sym, got.sym_valid, got.run_last, got.done, got.err);
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

/* sim.f */
design/itp_pkg.sv
design/itp_fifo.sv
design/itp_front.sv
design/itp_back.sv
design/infix_to_postfix_converter.sv
tb/tb.sv
